/* design/lsqs_pkg.sv */
// lsqs_pkg: shared types, constants and key compare for the least-service scheduler
// used by every module of the block; no dependencies
`timescale 1ns / 1ps

package lsqs_pkg;

  localparam int TABLE_DEPTH_DEF   = 2048;
  localparam int PENDING_DEPTH_DEF = 16;
  localparam int ID_W              = 31;
  localparam int SVC_W             = 24;
  localparam int EV_W              = 3;
  localparam int QLEN_W            = 8;
  localparam int TICK_W            = 32;
  localparam logic [QLEN_W-1:0] QUANTUM_RESET = 8'd5;

  localparam logic [EV_W-1:0] EV_NONE      = 3'd0;
  localparam logic [EV_W-1:0] EV_COMPLETED = 3'd1;
  localparam logic [EV_W-1:0] EV_TAKEN     = 3'd2;
  localparam logic [EV_W-1:0] EV_DEFERRED  = 3'd3;
  localparam logic [EV_W-1:0] EV_REJECTED  = 3'd4;

  localparam logic CMD_TICK   = 1'b0;
  localparam logic CMD_INSERT = 1'b1;

  typedef struct packed {
    logic [ID_W-1:0]  id;
    logic [SVC_W-1:0] served;
    logic [SVC_W-1:0] needed;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef struct packed {
    logic [ID_W-1:0]  id;
    logic [SVC_W-1:0] needed;
  } pend_t;

  // heap order: least service first, smaller id on a tie
  function automatic logic key_less(entry_t a, entry_t b);
    logic res;
    if (a.served != b.served) res = (a.served < b.served);
    else res = (a.id < b.id);
    return res;
  endfunction

endpackage

/* design/lsqs_ram.sv */
// lsqs_ram: heap table storage, one write and one registered read per cycle
// depends on lsqs_pkg for the entry layout
`timescale 1ns / 1ps

module lsqs_ram #(
  parameter int DEPTH = lsqs_pkg::TABLE_DEPTH_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic                   clk,
  input  logic                   we,
  input  logic [AW-1:0]          waddr,
  input  lsqs_pkg::entry_t       wdata,
  input  logic                   re,
  input  logic [AW-1:0]          raddr,
  output lsqs_pkg::entry_t       rdata
);

  lsqs_pkg::entry_t mem [DEPTH];
  lsqs_pkg::entry_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (re) rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

/* design/lsqs_cell.sv */
// lsqs_cell: one slot of the pending chain; loads a new item or takes its
// upper neighbor's item when the chain advances; depends on lsqs_pkg
`timescale 1ns / 1ps

module lsqs_cell (
  input  logic            clk,
  input  logic            load,
  input  logic            shift,
  input  lsqs_pkg::pend_t new_item,
  input  lsqs_pkg::pend_t from_up,
  output lsqs_pkg::pend_t held
);

  lsqs_pkg::pend_t held_r;

  always_ff @(posedge clk) begin
    if (shift) held_r <= from_up;
    else if (load) held_r <= new_item;
  end

  assign held = held_r;

endmodule

/* design/least_service_quantum_scheduler.sv */
// least_service_quantum_scheduler: top level, control sequencer, heap sifting,
// pending chain of lsqs_cell and the quantum register; uses lsqs_pkg, lsqs_ram
//
//  channel  | handshake                      | payload
//  ---------+--------------------------------+--------------------------------------
//  input    | start, busy (taken: start&!busy)| in_cmd, in_job_id, in_needed_service
//  result   | out_valid (one-cycle strobe)   | out_event_res, out_done_id,
//           |                                |   out_finish_tick, out_all_done
//  config   | psel, penable, pwrite, pready  | paddr, pwdata, prdata
//
// deferred/rejected inserts and ticks inside a quantum or on an empty table finish
// without a sift; a quantum end or a completion sifts the heap down (states SD_A, SD_B
// and SD_C per level, one read port) and then each pending item sifts up (states UP_A
// and UP_B per level)
// reset clears all control state at once; no clearing pass over the table
// busy is high while an item is in work; results cannot be stalled

`timescale 1ns / 1ps

module least_service_quantum_scheduler #(
  parameter int TABLE_DEPTH   = lsqs_pkg::TABLE_DEPTH_DEF,
  parameter int PENDING_DEPTH = lsqs_pkg::PENDING_DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic                          in_cmd,
  input  logic [lsqs_pkg::ID_W-1:0]     in_job_id,
  input  logic [lsqs_pkg::SVC_W-1:0]    in_needed_service,
  output logic                          out_valid,
  output logic [lsqs_pkg::EV_W-1:0]     out_event_res,
  output logic [lsqs_pkg::ID_W-1:0]     out_done_id,
  output logic [lsqs_pkg::TICK_W-1:0]   out_finish_tick,
  output logic                          out_all_done,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [2:0]                    paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int IW = AW + 2;
  localparam int PW = $clog2(PENDING_DEPTH + 1);

  localparam logic [3:0] ST_IDLE   = 4'd0;
  localparam logic [3:0] ST_TK_CHK = 4'd1;
  localparam logic [3:0] ST_TK_LST = 4'd2;
  localparam logic [3:0] ST_SD_A   = 4'd3;
  localparam logic [3:0] ST_SD_B   = 4'd4;
  localparam logic [3:0] ST_SD_C   = 4'd5;
  localparam logic [3:0] ST_UP_A   = 4'd6;
  localparam logic [3:0] ST_UP_B   = 4'd7;
  localparam logic [3:0] ST_JOIN   = 4'd8;

  logic [3:0]                  state_r, state_nxt;
  logic [AW-1:0]               idx_r, idx_nxt;
  lsqs_pkg::entry_t            x_r, x_nxt;
  lsqs_pkg::entry_t            lft_r, lft_nxt;
  logic                        rv_r, rv_nxt;
  logic [CW-1:0]               cnt_r, cnt_nxt;
  logic [PW-1:0]               pcnt_r, pcnt_nxt;
  logic                        inq_r, inq_nxt;
  logic [lsqs_pkg::QLEN_W-1:0] qused_r, qused_nxt;
  logic [lsqs_pkg::QLEN_W-1:0] qlen_r;
  logic [lsqs_pkg::TICK_W-1:0] tick_r, tick_nxt;
  logic [lsqs_pkg::EV_W-1:0]   ev_r, ev_nxt;
  logic [lsqs_pkg::ID_W-1:0]   did_r, did_nxt;
  logic [lsqs_pkg::TICK_W-1:0] fin_r, fin_nxt;
  logic                        alld_r, alld_nxt;
  logic                        valid_r, valid_nxt;

  logic                        we, re;
  logic [AW-1:0]               waddr, raddr;
  lsqs_pkg::entry_t            wdata, rdata;
  logic                        push, pop;
  lsqs_pkg::pend_t             new_pend;
  lsqs_pkg::pend_t             chain [PENDING_DEPTH + 1];

  logic                        accept;
  logic [IW-1:0]               lidx, ridx;
  logic                        full;
  lsqs_pkg::entry_t            root_upd;
  logic [lsqs_pkg::QLEN_W:0]   qnext;

  lsqs_ram #(.DEPTH(TABLE_DEPTH), .AW(AW)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

  // pending chain: slot 0 is the oldest item, the chain advances toward it on a pop
  assign chain[PENDING_DEPTH] = new_pend;
  assign new_pend.id          = in_job_id;
  assign new_pend.needed      = in_needed_service;

  for (genvar k = 0; k < PENDING_DEPTH; k++) begin : g_cell
    lsqs_cell u_cell (
      .clk      (clk),
      .load     (push && (pcnt_r == PW'(k))),
      .shift    (pop),
      .new_item (new_pend),
      .from_up  (chain[k + 1]),
      .held     (chain[k])
    );
  end

  assign accept   = start && !busy;
  assign busy     = (state_r != ST_IDLE);
  assign lidx     = IW'({idx_r, 1'b1});
  assign ridx     = lidx + IW'(1);
  assign full     = (cnt_r == CW'(TABLE_DEPTH));
  assign qnext    = {1'b0, qused_r} + {{lsqs_pkg::QLEN_W{1'b0}}, 1'b1};

  always_comb begin
    root_upd        = rdata;
    root_upd.served = rdata.served + lsqs_pkg::SVC_W'(1);
  end

  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    x_nxt     = x_r;
    lft_nxt   = lft_r;
    rv_nxt    = rv_r;
    cnt_nxt   = cnt_r;
    pcnt_nxt  = pcnt_r;
    inq_nxt   = inq_r;
    qused_nxt = qused_r;
    tick_nxt  = tick_r;
    ev_nxt    = ev_r;
    did_nxt   = did_r;
    fin_nxt   = fin_r;
    alld_nxt  = alld_r;
    valid_nxt = 1'b0;
    we        = 1'b0;
    waddr     = idx_r;
    wdata     = x_r;
    re        = 1'b0;
    raddr     = '0;
    push      = 1'b0;
    pop       = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          fin_nxt  = '0;
          alld_nxt = 1'b0;
          if (in_cmd == lsqs_pkg::CMD_INSERT) begin
            did_nxt = in_job_id;
            if (!inq_r) begin
              if (full) begin
                ev_nxt    = lsqs_pkg::EV_REJECTED;
                valid_nxt = 1'b1;
              end else begin
                ev_nxt    = lsqs_pkg::EV_TAKEN;
                x_nxt     = '{id: in_job_id, served: '0, needed: in_needed_service};
                idx_nxt   = cnt_r[AW-1:0];
                cnt_nxt   = cnt_r + CW'(1);
                state_nxt = ST_UP_A;
              end
            end else if (pcnt_r < PW'(PENDING_DEPTH)) begin
              push      = 1'b1;
              pcnt_nxt  = pcnt_r + PW'(1);
              ev_nxt    = lsqs_pkg::EV_DEFERRED;
              valid_nxt = 1'b1;
            end else begin
              ev_nxt    = lsqs_pkg::EV_REJECTED;
              valid_nxt = 1'b1;
            end
          end else begin
            tick_nxt = tick_r + lsqs_pkg::TICK_W'(1);
            did_nxt  = '0;
            ev_nxt   = lsqs_pkg::EV_NONE;
            if (cnt_r == '0) begin
              valid_nxt = 1'b1;
            end else begin
              re        = 1'b1;
              raddr     = '0;
              state_nxt = ST_TK_CHK;
            end
          end
        end
      end
      ST_TK_CHK: begin
        if (root_upd.served >= root_upd.needed) begin
          ev_nxt  = lsqs_pkg::EV_COMPLETED;
          did_nxt = root_upd.id;
          fin_nxt = tick_r;
          cnt_nxt = cnt_r - CW'(1);
          if (cnt_r != CW'(1)) begin
            re        = 1'b1;
            raddr     = cnt_nxt[AW-1:0];
            state_nxt = ST_TK_LST;
          end else begin
            state_nxt = ST_JOIN;
          end
        end else if (qnext >= {1'b0, qlen_r}) begin
          x_nxt     = root_upd;
          idx_nxt   = '0;
          state_nxt = ST_SD_A;
        end else begin
          we        = 1'b1;
          waddr     = '0;
          wdata     = root_upd;
          qused_nxt = qnext[lsqs_pkg::QLEN_W-1:0];
          inq_nxt   = 1'b1;
          valid_nxt = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      ST_TK_LST: begin
        x_nxt     = rdata;
        idx_nxt   = '0;
        state_nxt = ST_SD_A;
      end
      // sift down with the moving item held in x_r, hole at idx_r
      ST_SD_A: begin
        if (lidx >= IW'(cnt_r)) begin
          we        = 1'b1;
          state_nxt = ST_JOIN;
        end else begin
          re        = 1'b1;
          raddr     = lidx[AW-1:0];
          state_nxt = ST_SD_B;
        end
      end
      ST_SD_B: begin
        lft_nxt = rdata;
        rv_nxt  = (ridx < IW'(cnt_r));
        if (ridx < IW'(cnt_r)) begin
          re    = 1'b1;
          raddr = ridx[AW-1:0];
        end
        state_nxt = ST_SD_C;
      end
      ST_SD_C: begin
        we = 1'b1;
        if (lsqs_pkg::key_less(lft_r, x_r)) begin
          if (rv_r && lsqs_pkg::key_less(rdata, lft_r)) begin
            wdata   = rdata;
            idx_nxt = ridx[AW-1:0];
          end else begin
            wdata   = lft_r;
            idx_nxt = lidx[AW-1:0];
          end
          state_nxt = ST_SD_A;
        end else if (rv_r && lsqs_pkg::key_less(rdata, x_r)) begin
          wdata     = rdata;
          idx_nxt   = ridx[AW-1:0];
          state_nxt = ST_SD_A;
        end else begin
          state_nxt = ST_JOIN;
        end
      end
      // sift up with the moving item held in x_r
      ST_UP_A: begin
        if (idx_r == '0) begin
          we        = 1'b1;
          state_nxt = ST_JOIN;
        end else begin
          re        = 1'b1;
          raddr     = (idx_r - AW'(1)) >> 1;
          state_nxt = ST_UP_B;
        end
      end
      ST_UP_B: begin
        we = 1'b1;
        if (lsqs_pkg::key_less(x_r, rdata)) begin
          wdata     = rdata;
          idx_nxt   = (idx_r - AW'(1)) >> 1;
          state_nxt = ST_UP_A;
        end else begin
          state_nxt = ST_JOIN;
        end
      end
      // end of a quantum, completion or insert: drain the pending chain in arrival order, into the heap if not full
      ST_JOIN: begin
        if (pcnt_r == '0) begin
          inq_nxt   = 1'b0;
          qused_nxt = '0;
          alld_nxt  = (ev_r == lsqs_pkg::EV_COMPLETED) && (cnt_r == '0);
          valid_nxt = 1'b1;
          state_nxt = ST_IDLE;
        end else begin
          pop      = 1'b1;
          pcnt_nxt = pcnt_r - PW'(1);
          if (!full) begin
            x_nxt     = '{id: chain[0].id, served: '0, needed: chain[0].needed};
            idx_nxt   = cnt_r[AW-1:0];
            cnt_nxt   = cnt_r + CW'(1);
            state_nxt = ST_UP_A;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
      pcnt_r  <= '0;
      inq_r   <= 1'b0;
      qused_r <= '0;
      tick_r  <= '0;
      valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      pcnt_r  <= pcnt_nxt;
      inq_r   <= inq_nxt;
      qused_r <= qused_nxt;
      tick_r  <= tick_nxt;
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r  <= idx_nxt;
    x_r    <= x_nxt;
    lft_r  <= lft_nxt;
    rv_r   <= rv_nxt;
    ev_r   <= ev_nxt;
    did_r  <= did_nxt;
    fin_r  <= fin_nxt;
    alld_r <= alld_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      qlen_r <= lsqs_pkg::QUANTUM_RESET;
    end else if (psel && penable && pwrite && !paddr[2]) begin
      qlen_r <= pwdata[lsqs_pkg::QLEN_W-1:0];
    end
  end

  assign pready          = 1'b1;
  assign prdata          = paddr[2] ? 32'd0 : {{(32 - lsqs_pkg::QLEN_W){1'b0}}, qlen_r};
  assign out_valid       = valid_r;
  assign out_event_res   = ev_r;
  assign out_done_id     = did_r;
  assign out_finish_tick = fin_r;
  assign out_all_done    = alld_r;

endmodule

/* design/lsqs_chk.sv */
// lsqs_chk: port-level checks on the scheduler over time, bound to the top level
// depends on lsqs_pkg for event codes
`timescale 1ns / 1ps

module lsqs_chk (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          start,
  input logic                          busy,
  input logic                          out_valid,
  input logic [lsqs_pkg::EV_W-1:0]     out_event_res,
  input logic [lsqs_pkg::TICK_W-1:0]   out_finish_tick,
  input logic                          out_all_done
);

  // an accepted item either finishes at once or keeps the block busy
  a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (busy || out_valid))
    else $error("accepted item neither busy nor finished");

  // a result never appears while the block is still busy
  a_result_when_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result strobe while busy");

  a_event_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_event_res == lsqs_pkg::EV_NONE ||
                   out_event_res == lsqs_pkg::EV_COMPLETED ||
                   out_event_res == lsqs_pkg::EV_TAKEN ||
                   out_event_res == lsqs_pkg::EV_DEFERRED ||
                   out_event_res == lsqs_pkg::EV_REJECTED))
    else $error("event code out of range");

  // only a completion carries a finish tick or the all-done flag
  a_non_completion_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_event_res != lsqs_pkg::EV_COMPLETED) |->
      (out_finish_tick == '0 && !out_all_done))
    else $error("finish tick or all-done on a non-completion");

endmodule

bind least_service_quantum_scheduler lsqs_chk u_lsqs_chk (
  .clk             (clk),
  .rst_n           (rst_n),
  .start           (start),
  .busy            (busy),
  .out_valid       (out_valid),
  .out_event_res   (out_event_res),
  .out_finish_tick (out_finish_tick),
  .out_all_done    (out_all_done)
);
